// File: rtl/mwr_pkg.sv
// ----------------------------------------------------------------------------
// mwr_pkg: shared types for the 2-D window range block
// Word types for both channels, the queued item and register indexes.
// ----------------------------------------------------------------------------
package mwr_pkg;

  // register indexes of the configuration port
  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_IMAGE_WIDTH = 1'b1;

  // widest values the parameters allow
  localparam int unsigned PIX_MAX_W  = 32;
  localparam int unsigned COL_MAX_W  = 12;
  localparam int unsigned SLOT_MAX_W = 6;
  localparam int unsigned WIN_MAX_W  = 7;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        last_pixel;
  } in_word_t;

  typedef struct packed {
    logic [15:0] min_range;
    logic        window_found;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [PIX_MAX_W-1:0]  pix;
    logic [COL_MAX_W-1:0]  col;
    logic [SLOT_MAX_W-1:0] slot;
    logic [WIN_MAX_W-1:0]  win;
    logic                  new_row;
    logic                  vert;
    logic                  last;
  } item_t;

endpackage

// File: rtl/mwr_queue.sv
// ----------------------------------------------------------------------------
// mwr_queue: two-entry queue
// Decouples the classifying front from the executing back.
// ----------------------------------------------------------------------------
module mwr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mwr_pkg::item_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mwr_pkg::item_t data_o
);
  import mwr_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: rtl/mwr_front.sv
// ----------------------------------------------------------------------------
// mwr_front: configuration and raster tracking
// Holds the registers, follows column, row and line slot, tags each word.
// ----------------------------------------------------------------------------
module mwr_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [10:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mwr_pkg::in_word_t in_i,
  output logic              push_o,
  input  logic              full_i,
  output mwr_pkg::item_t    item_o
);
  import mwr_pkg::*;

  localparam int unsigned CNW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RCW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [4:0]     win_cfg_q;
  logic [10:0]    width_cfg_q;
  logic [CNW-1:0] col_q, col_d, c;
  logic [RCW-1:0] rc_q, rc_d;
  logic [SW-1:0]  slot_q, slot_d;
  logic           new_row;
  int unsigned    k_eff, w_eff;
  logic [31:0]    pix32;

  // row count seen by this word, before the end-of-image clear
  function automatic logic [RCW-1:0] rc_d_sat(logic [RCW-1:0] rc, logic nr);
    logic [RCW-1:0] r;
    r = rc;
    if (nr && 32'(rc) < MAX_WINDOW) r = rc + RCW'(1);
    return r;
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign pix32      = 32'(in_i.pixel_value);

  always_comb begin
    k_eff = 32'(win_cfg_q);
    if (k_eff == 0) k_eff = 1;
    if (k_eff > MAX_WINDOW) k_eff = MAX_WINDOW;
    w_eff = 32'(width_cfg_q);
    if (w_eff == 0) w_eff = 1;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
  end

  always_comb begin
    rc_d    = rc_q;
    slot_d  = slot_q;
    c       = col_q;
    new_row = 1'b0;
    if (rc_q == '0) begin
      rc_d    = RCW'(1);
      slot_d  = '0;
      c       = '0;
      new_row = 1'b1;
    end else if (32'(col_q) >= w_eff) begin
      c       = '0;
      new_row = 1'b1;
      slot_d  = (32'(slot_q) == MAX_WINDOW - 1) ? '0 : slot_q + SW'(1);
      if (32'(rc_q) < MAX_WINDOW) rc_d = rc_q + RCW'(1);
    end
    col_d = c + CNW'(1);
    if (in_i.last_pixel) rc_d = '0;
  end

  always_comb begin
    item_o.pix     = PIX_MAX_W'(pix32[PIXEL_BITS-1:0]);
    item_o.col     = COL_MAX_W'(c);
    item_o.slot    = SLOT_MAX_W'(slot_d);
    item_o.win     = WIN_MAX_W'(k_eff);
    item_o.new_row = new_row;
    item_o.vert    = (32'(c) + 1 >= k_eff) &&
                     (32'((rc_q == '0) ? RCW'(1) : rc_d_sat(rc_q, new_row)) >= k_eff);
    item_o.last    = in_i.last_pixel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q   <= 5'd1;
      width_cfg_q <= 11'd1024;
      col_q       <= '0;
      rc_q        <= '0;
      slot_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE: win_cfg_q   <= cfg_data_i[4:0];
          CFG_IMAGE_WIDTH: width_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_o) begin
        col_q  <= col_d;
        rc_q   <= rc_d;
        slot_q <= slot_d;
      end
    end
  end

endmodule

// File: rtl/mwr_back.sv
// ----------------------------------------------------------------------------
// mwr_back: row window, line stores and vertical pass
// Sequences one item at a time and drives the registered result word.
// ----------------------------------------------------------------------------
module mwr_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  mwr_pkg::item_t     item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mwr_pkg::out_word_t out_o
);
  import mwr_pkg::*;

  localparam int unsigned PB    = PIXEL_BITS;
  localparam int unsigned SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned KW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROW  = 6'b000010,
    S_WR   = 6'b000100,
    S_RD   = 6'b001000,
    S_ACC  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  item_t           cur_q;
  logic [PB-1:0]   tap_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] alive_q;
  logic [KW-1:0]   j_q, j_d, k;
  logic [PB-1:0]   amax_q, amax_d, amin_q, amin_d;
  logic [PB-1:0]   best_q, best_d;
  logic            found_q, found_d;
  logic            out_valid_q;
  out_word_t       out_q;
  logic [2*PB-1:0] mem [DEPTH];
  logic [2*PB-1:0] rd_q;
  logic            mem_we, mem_re, out_free, emit;
  logic [AW-1:0]   wa, ra;
  logic [SW-1:0]   rslot;
  logic [PB-1:0]   tap_j, rng;
  logic [31:0]     best32;

  assign k           = cur_q.win[KW-1:0];
  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign tap_j       = tap_q[j_q[SW-1:0]];
  assign mem_we      = (state_q == S_WR);
  assign mem_re      = (state_q == S_RD);
  assign wa = AW'(32'(cur_q.slot[SW-1:0]) * MAX_WIDTH + 32'(cur_q.col[CW-1:0]));
  assign rslot = (32'(cur_q.slot[SW-1:0]) >= 32'(j_q)) ?
                 SW'(32'(cur_q.slot[SW-1:0]) - 32'(j_q)) :
                 SW'(32'(cur_q.slot[SW-1:0]) + MAX_WINDOW - 32'(j_q));
  assign ra  = AW'(32'(rslot) * MAX_WIDTH + 32'(cur_q.col[CW-1:0]));
  assign rng = amax_q - amin_q;
  assign emit = (state_q == S_FIN) && cur_q.last && out_free;

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    amax_d  = amax_q;
    amin_d  = amin_q;
    best_d  = best_q;
    found_d = found_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          amax_d  = item_i.pix[PB-1:0];
          amin_d  = item_i.pix[PB-1:0];
          j_d     = KW'(1);
          state_d = (item_i.win == WIN_MAX_W'(1)) ? S_WR : S_ROW;
        end
      end
      S_ROW: begin
        if (alive_q[j_q[SW-1:0]]) begin
          if (tap_j > amax_q) amax_d = tap_j;
          if (tap_j < amin_q) amin_d = tap_j;
        end
        j_d = j_q + KW'(1);
        if (j_q == k - KW'(1)) state_d = S_WR;
      end
      S_WR: begin
        j_d = KW'(1);
        if (cur_q.vert && k != KW'(1)) state_d = S_RD;
        else state_d = S_FIN;
      end
      S_RD: state_d = S_ACC;
      S_ACC: begin
        if (rd_q[2*PB-1:PB] > amax_q) amax_d = rd_q[2*PB-1:PB];
        if (rd_q[PB-1:0] < amin_q) amin_d = rd_q[PB-1:0];
        j_d = j_q + KW'(1);
        state_d = (j_q == k - KW'(1)) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (cur_q.vert) begin
          found_d = 1'b1;
          if (amax_q < amin_q) best_d = '0;
          else if (!found_q || rng < best_q) best_d = rng;
        end
        if (!cur_q.last || out_free) state_d = S_IDLE;
        else begin
          found_d = found_q;
          best_d  = best_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign best32 = 32'(best_d);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wa] <= {amax_q, amin_q};
    if (mem_re) rd_q <= mem[ra];
  end

  // shift line of the current row; alive marks taps still inside the window
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q    <= item_i;
      tap_q[0] <= item_i.pix[PB-1:0];
      for (int i = 1; i < MAX_WINDOW; i++) tap_q[i] <= tap_q[i-1];
    end
    amax_q <= amax_d;
    amin_q <= amin_d;
    j_q    <= j_d;
    best_q <= best_d;
    if (emit) begin
      out_q.min_range    <= found_d ? best32[15:0] : 16'd0;
      out_q.window_found <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alive_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= emit ? 1'b0 : found_d;
      if (pop_o) begin
        alive_q[0] <= 1'b1;
        for (int i = 1; i < MAX_WINDOW; i++) begin
          alive_q[i] <= !item_i.new_row && alive_q[i-1] && (32'(i) < 32'(item_i.win));
        end
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_row_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW) |-> (j_q < k))
    else $error("row tap index beyond window");
  a_vert_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (j_q < k) && cur_q.vert)
    else $error("vertical pass out of range");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result word lost");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_ROW) || (state_q == S_WR))
    else $error("item start mis-sequenced");
`endif

endmodule

// File: rtl/min_window_range_2d.sv
// ----------------------------------------------------------------------------
// min_window_range_2d: smallest max-minus-min over all K x K windows
// Raster pixel stream in, one result word on the last pixel of each image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; the front tracks column, row and line slot
// and queues each word, the back works one word at a time: it walks the
// row shift line (row window max and min), writes the line store, then for
// a complete window reads the line store for each of the K-1 earlier rows
// with a read step and an accumulate step, and ends with a final update.
// The line store holds MAX_WINDOW x MAX_WIDTH entries and needs no clearing.
// A result word appears only on the pixel flagged last; window_found low
// means no full window existed and min_range is then zero.
module min_window_range_2d #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mwr_pkg::in_word_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mwr_pkg::out_word_t out_o
);
  import mwr_pkg::*;

  logic  push, full, pop, empty;
  item_t q_in, q_out;

  // front: registers and raster position
  mwr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i      (in_i),
    .push_o    (push),
    .full_i    (full),
    .item_o    (q_in)
  );

  mwr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (q_out)
  );

  // back: window arithmetic and result register
  mwr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (q_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for min_window_range_2d
// Streams raster images through the block under a range of window and width
// settings and checks each end-of-image word against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mwr_pkg::*;

  localparam int unsigned LINE_W   = 1024;
  localparam int unsigned WIN_MAX  = 16;
  localparam int unsigned STALL_TO = 20000;  // idle cycles before giving up
  localparam int unsigned SETTLE   = 100;    // longer than the worst time the back spends on a word

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_idx = CFG_WINDOW_SIZE;
  logic [10:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  always #10 clk_i = ~clk_i;

  min_window_range_2d uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_word)
  );

  // ---- predictor state: registers, row deques, line stores, image tally ----
  logic [4:0]  win_reg = 5'd1;
  logic [10:0] width_reg = 11'd1024;
  int unsigned dq_col [2][WIN_MAX];   // [0] keeps max, [1] keeps min
  int unsigned dq_val [2][WIN_MAX];
  int unsigned dq_head [2];
  int unsigned dq_cnt [2];
  int unsigned max_line [WIN_MAX*LINE_W];
  int unsigned min_line [WIN_MAX*LINE_W];
  int unsigned col_cnt, row_cnt, slot;
  int unsigned best;
  bit          found;

  out_word_t   range_q [$];   // end-of-image words still owed by the block

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  int unsigned images = 0;
  bit          quiet = 1'b0;      // no random idling while set
  int unsigned hold_len = 0;      // receiver hold-off request, in cycles

  function automatic void image_restart();
    dq_cnt[0] = 0; dq_cnt[1] = 0; dq_head[0] = 0; dq_head[1] = 0;
    col_cnt = 0; row_cnt = 0; slot = 0;
    best = 32'hFFFF_FFFF; found = 1'b0;
  endfunction

  // monotonic deque push; returns the current window extreme
  function automatic int unsigned dq_push(int sel, int unsigned c, int unsigned v,
                                          int unsigned k);
    int unsigned b, t;
    bit drop;
    while (dq_cnt[sel] > 0 && dq_col[sel][dq_head[sel]] + k <= c) begin
      dq_head[sel] = (dq_head[sel] + 1) % WIN_MAX;
      dq_cnt[sel]--;
    end
    while (dq_cnt[sel] > 0) begin
      b = (dq_head[sel] + dq_cnt[sel] - 1) % WIN_MAX;
      drop = (sel == 0) ? (dq_val[sel][b] <= v) : (dq_val[sel][b] >= v);
      if (!drop) break;
      dq_cnt[sel]--;
    end
    if (dq_cnt[sel] >= WIN_MAX) begin
      dq_head[sel] = (dq_head[sel] + 1) % WIN_MAX;
      dq_cnt[sel]--;
    end
    t = (dq_head[sel] + dq_cnt[sel]) % WIN_MAX;
    dq_col[sel][t] = c;
    dq_val[sel][t] = v;
    dq_cnt[sel]++;
    return dq_val[sel][dq_head[sel]];
  endfunction

  function automatic void predict_pixel(in_word_t w_in);
    int unsigned k, w, c, p, vmax, vmin, s;
    out_word_t   o;
    k = win_reg;   if (k == 0) k = 1;  if (k > WIN_MAX) k = WIN_MAX;
    w = width_reg; if (w == 0) w = 1;  if (w > LINE_W) w = LINE_W;
    if (row_cnt == 0) begin
      row_cnt = 1; slot = 0; col_cnt = 0;
      dq_cnt[0] = 0; dq_cnt[1] = 0; dq_head[0] = 0; dq_head[1] = 0;
    end else if (col_cnt >= w) begin
      col_cnt = 0;
      slot = (slot + 1) % WIN_MAX;
      if (row_cnt < WIN_MAX) row_cnt++;
      dq_cnt[0] = 0; dq_cnt[1] = 0; dq_head[0] = 0; dq_head[1] = 0;
    end
    c = col_cnt;
    p = slot*LINE_W + c;
    max_line[p] = dq_push(0, c, w_in.pixel_value, k);
    min_line[p] = dq_push(1, c, w_in.pixel_value, k);
    if (c + 1 >= k && row_cnt >= k) begin
      vmax = 0; vmin = 32'hFFFF_FFFF;
      for (int unsigned t = 0; t < k; t++) begin
        s = (slot + WIN_MAX - t) % WIN_MAX;
        if (max_line[s*LINE_W + c] > vmax) vmax = max_line[s*LINE_W + c];
        if (min_line[s*LINE_W + c] < vmin) vmin = min_line[s*LINE_W + c];
      end
      if (vmax >= vmin && vmax - vmin < best) best = vmax - vmin;
      if (vmax < vmin && best > 0) best = 0;
      found = 1'b1;
    end
    col_cnt = c + 1;
    if (w_in.last_pixel) begin
      o.min_range    = found ? best[15:0] : 16'd0;
      o.window_found = found;
      range_q.push_back(o);
      image_restart();
    end
  endfunction

  // ---- sender: one word per call, valid held until accepted ----
  task automatic send_pixel(logic [15:0] pix, logic last);
    in_word_t w;
    w.pixel_value = pix;
    w.last_pixel  = last;
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    predict_pixel(w);
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
    if (last) images++;
  endtask

  // wait for every owed word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (range_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic idx, logic [10:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) win_reg = val[4:0];
    else width_reg = val;
  endtask

  function automatic logic [15:0] pick_pixel(int unsigned base, int unsigned mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'(base + $urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'(base + $urandom_range(0, 255));
    endcase
  endfunction

  // one image of npix pixels, last flag on the final one
  task automatic send_image(int unsigned npix);
    int unsigned base, mode;
    base = $urandom();
    mode = $urandom_range(0, 3);
    for (int unsigned i = 0; i < npix; i++)
      send_pixel(pick_pixel(base, mode), i == npix - 1);
  endtask

  // ---- tests ----
  task automatic test_reset_defaults();
    // K=1, width 1024: every pixel is a full window, range 0
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hFFFF, 1'b1);   // one-pixel image
  endtask

  task automatic test_directed();
    write_reg(CFG_WINDOW_SIZE, 11'd2);
    write_reg(CFG_IMAGE_WIDTH, 11'd2);
    send_pixel(16'h0000, 1'b0); send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0); send_pixel(16'h0000, 1'b1);
    // no full window: four columns wide, one and a bit rows
    write_reg(CFG_WINDOW_SIZE, 11'd3);
    write_reg(CFG_IMAGE_WIDTH, 11'd4);
    for (int i = 0; i < 5; i++) send_pixel(16'(i * 100), i == 4);
    // zero window acts as 1, zero width acts as 1
    write_reg(CFG_WINDOW_SIZE, 11'd0);
    write_reg(CFG_IMAGE_WIDTH, 11'd0);
    send_pixel(16'h8000, 1'b0); send_pixel(16'h7FFF, 1'b1);
    // oversize window clamps to 16; wide register clamps to 1024, partial row
    write_reg(CFG_WINDOW_SIZE, 11'd31);
    write_reg(CFG_IMAGE_WIDTH, 11'd2047);
    for (int i = 0; i < 6; i++) send_pixel(16'($urandom()), i == 5);
    write_reg(CFG_WINDOW_SIZE, 11'd1);
    for (int i = 0; i < 4; i++) send_pixel(16'($urandom()), i == 3);
  endtask

  task automatic test_largest_window();
    // K=16 on a 16x16 image: exactly one full window
    write_reg(CFG_WINDOW_SIZE, 11'd16);
    write_reg(CFG_IMAGE_WIDTH, 11'd16);
    send_image(256);
  endtask

  task automatic test_random_images(int unsigned budget);
    int unsigned k, w, rows, npix, start;
    start = words_sent;
    while (words_sent - start < budget) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      w = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 20);
      write_reg(CFG_WINDOW_SIZE, 11'(k));
      write_reg(CFG_IMAGE_WIDTH, 11'(w));
      if (w == 0) w = 1;
      rows = $urandom_range(1, 5);
      npix = rows * w;
      // a partial last row now and then
      if ($urandom_range(0, 3) == 0) npix = npix - $urandom_range(0, w - 1);
      send_image(npix);
      // now and then a second small image back to back with the same settings
      if ($urandom_range(0, 1)) send_image($urandom_range(1, 3 * w));
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WINDOW_SIZE, 11'd1);
    write_reg(CFG_IMAGE_WIDTH, 11'd2);
    quiet = 1'b1;
    hold_len = 400;   // receiver stalls while the block backs up
    for (int i = 0; i < 8; i++) send_image(3);
    quiet = 1'b0;
    // sender pauses until everything is back
    drain();
    send_image(5);
  endtask

  // ---- receiver ready, with random and requested stalls ----
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // ---- result check against the oldest owed word ----
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid && out_ready) begin
      words_seen++;
      if (range_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: min_range %0d window_found %0d",
                   out_word.min_range, out_word.window_found);
      end else begin
        exp_w = range_q.pop_front();
        if (out_word.min_range !== exp_w.min_range ||
            out_word.window_found !== exp_w.window_found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: min_range exp %0d got %0d, window_found exp %0d got %0d",
                     exp_w.min_range, out_word.min_range,
                     exp_w.window_found, out_word.window_found);
        end
      end
    end
  end

  // ---- watchdog on cycles with no handshake on either side ----
  initial begin
    int unsigned idle_cnt;
    idle_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= STALL_TO) begin
        $display("timeout with %0d words owed", range_q.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    image_restart();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_largest_window();
    quiet = 1'b1;           // long stretch without idling on either side
    test_random_images(70);
    quiet = 1'b0;
    test_backpressure();
    test_random_images(150);
    drain();
    $display("covered %0d images, %0d pixels in, %0d result words checked",
             images, words_sent, words_seen);
    $display("windows 0..31 (clamped), widths 0..2047, partial rows, stalls");
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
